### hdl/trial_division_prime_test_defines.svh
// Assertion macros for the trial division prime test.
// Standalone header; trial_division_prime_test.sv includes it to check its logic.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef SYNTHESIS
// combinational property checked at every rising clock edge outside reset
`define TDPT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tdpt assertion failed");
// implication from one cycle to the next
`define TDPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tdpt sequencing assertion failed");
`else
`define TDPT_ASSERT(lbl, clk, rstn, prop)
`define TDPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/tdpt_pkg.sv
// Package for the trial division prime test: widths, divisor constants,
// sequencer state and control types. No dependencies.
package tdpt_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH);

  localparam logic [VALUE_WIDTH-1:0] DIV_THREE = VALUE_WIDTH'(3);
  localparam logic [VALUE_WIDTH-1:0] DIV_FIRST = VALUE_WIDTH'(5);
  localparam logic [VALUE_WIDTH-1:0] DIV_STEP  = VALUE_WIDTH'(6);
  localparam logic [VALUE_WIDTH-1:0] DIV_GAP   = VALUE_WIDTH'(2);
  localparam logic [CNT_W-1:0]       CNT_LAST  = CNT_W'(VALUE_WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_EVAL,
    S_OUT
  } state_e;

  // which divisor the shared divider is working on
  typedef enum logic [1:0] {
    K_THREE,
    K_LO,
    K_HI
  } kind_e;

  typedef struct packed {
    logic accept;
    logic ld_div;
    logic step;
    logic eval;
    logic out_ld;
  } ctrl_t;

endpackage

### hdl/trial_division_prime_test.sv
// Trial division prime test, 6k +/- 1 divisors, on one shared restoring divider.
// Depends on tdpt_pkg and trial_division_prime_test_defines.svh.
//
//  channel | signals                              | dir
//  --------+--------------------------------------+-----
//  in      | in_valid_i, in_stall_o, candidate_i  | in
//  out     | out_valid_o, out_stall_i, is_prime_o | out
//
// Negative, 0..3 and even candidates skip the divider. Others run the
// divider one quotient bit per cycle, for divisor 3 and then two divisors per
// step of 6 (6k - 1 and 6k + 1), until a divisor divides or passes the
// square root. The divider loop sets the rate.
// in_stall_o is high while an item is being tested; the output register lets
// the next item enter while a result waits. Reset clears control state only.
`include "trial_division_prime_test_defines.svh"

module trial_division_prime_test (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] candidate_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    is_prime_o
);

  localparam int unsigned W = tdpt_pkg::VALUE_WIDTH;

  tdpt_pkg::state_e state_q, state_d;
  tdpt_pkg::kind_e  kind_q;
  tdpt_pkg::ctrl_t  ctrl;

  logic [W-1:0]                 v_q;
  logic [W-1:0]                 d_q;
  logic [W-1:0]                 div_q;
  logic [W-1:0]                 rem_q;
  logic [W-1:0]                 quo_q;
  logic [tdpt_pkg::CNT_W-1:0]   cnt_q;
  logic                         flag_q;
  logic                         out_valid_q;
  logic                         out_flag_q;

  logic [W:0]   trial;
  logic         borrow;
  logic         rem_zero;
  logic         past_bound;
  logic         direct;
  logic         direct_flag;
  logic [W-1:0] cand_u;

  assign cand_u = W'(candidate_i);

  // screening of items that need no division
  always_comb begin
    direct      = 1'b1;
    direct_flag = 1'b0;
    if (cand_u[W-1]) begin
      direct_flag = 1'b0;
    end else if (cand_u[W-1:2] == '0) begin
      direct_flag = cand_u[1];
    end else if (!cand_u[0]) begin
      direct_flag = 1'b0;
    end else begin
      direct = 1'b0;
    end
  end

  assign trial      = {rem_q, quo_q[W-1]} - {1'b0, div_q};
  assign borrow     = trial[W];
  assign rem_zero   = (rem_q == '0);
  assign past_bound = (div_q > quo_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tdpt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = direct ? tdpt_pkg::S_OUT : tdpt_pkg::S_LOAD;
        end
      end
      tdpt_pkg::S_LOAD: state_d = tdpt_pkg::S_DIV;
      tdpt_pkg::S_DIV: begin
        if (cnt_q == '0) begin
          state_d = tdpt_pkg::S_EVAL;
        end
      end
      tdpt_pkg::S_EVAL: begin
        case (kind_q)
          tdpt_pkg::K_LO:
            state_d = (past_bound || rem_zero) ? tdpt_pkg::S_OUT : tdpt_pkg::S_LOAD;
          default:
            state_d = rem_zero ? tdpt_pkg::S_OUT : tdpt_pkg::S_LOAD;
        endcase
      end
      tdpt_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = tdpt_pkg::S_IDLE;
        end
      end
      default: state_d = tdpt_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl       = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tdpt_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        ctrl.accept = in_valid_i;
      end
      tdpt_pkg::S_LOAD: ctrl.ld_div = 1'b1;
      tdpt_pkg::S_DIV:  ctrl.step   = 1'b1;
      tdpt_pkg::S_EVAL: ctrl.eval   = 1'b1;
      tdpt_pkg::S_OUT:  ctrl.out_ld = !out_valid_q || !out_stall_i;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::S_IDLE;
      kind_q      <= tdpt_pkg::K_THREE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl.accept) begin
        kind_q <= tdpt_pkg::K_THREE;
      end else if (ctrl.eval) begin
        case (kind_q)
          tdpt_pkg::K_LO: kind_q <= tdpt_pkg::K_HI;
          default:        kind_q <= tdpt_pkg::K_LO;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      v_q    <= cand_u;
      flag_q <= direct_flag;
    end
    if (ctrl.ld_div) begin
      case (kind_q)
        tdpt_pkg::K_THREE: div_q <= tdpt_pkg::DIV_THREE;
        tdpt_pkg::K_HI:    div_q <= d_q + tdpt_pkg::DIV_GAP;
        default:           div_q <= d_q;
      endcase
      rem_q <= '0;
      quo_q <= v_q;
      cnt_q <= tdpt_pkg::CNT_LAST;
    end
    if (ctrl.step) begin
      rem_q <= borrow ? {rem_q[W-2:0], quo_q[W-1]} : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], !borrow};
      cnt_q <= cnt_q - 1'b1;
    end
    if (ctrl.eval) begin
      case (kind_q)
        tdpt_pkg::K_THREE: begin
          flag_q <= 1'b0;
          d_q    <= tdpt_pkg::DIV_FIRST;
        end
        tdpt_pkg::K_LO: begin
          // past the square root: no divisor found
          flag_q <= past_bound;
        end
        default: begin
          flag_q <= 1'b0;
          d_q    <= d_q + tdpt_pkg::DIV_STEP;
        end
      endcase
    end
    if (ctrl.out_ld) begin
      out_flag_q <= flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_flag_q;

  `TDPT_ASSERT(a_rem_below_div, clk_i, rst_ni, (state_q != tdpt_pkg::S_DIV) || (rem_q < div_q))
  `TDPT_ASSERT(a_lo_div_matches, clk_i, rst_ni,
               (state_q != tdpt_pkg::S_EVAL) || (kind_q != tdpt_pkg::K_LO) || (div_q == d_q))
  `TDPT_ASSERT(a_out_from_seq, clk_i, rst_ni,
               !$rose(out_valid_q) || ($past(state_q) == tdpt_pkg::S_OUT))
  `TDPT_ASSERT(a_div_odd, clk_i, rst_ni, (state_q != tdpt_pkg::S_DIV) || div_q[0])
  `TDPT_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, ctrl.accept,
                    state_q != tdpt_pkg::S_IDLE)

endmodule
